### hw/rtl/sprite_xor_framebuffer_core_assert.svh
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_core_assert.svh
// Assertion macros shared by the framebuffer checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_XOR_FRAMEBUFFER_CORE_ASSERT_SVH
`define SPRITE_XOR_FRAMEBUFFER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SXFB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("framebuffer assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SXFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("framebuffer assertion failed");

`endif

### hw/rtl/sxfb_pkg.sv
// ----------------------------------------------------------------------------
// sxfb_pkg
// Screen geometry, types and helper functions of the sprite framebuffer.
// ----------------------------------------------------------------------------
package sxfb_pkg;

  localparam int unsigned SCREEN_ROWS  = 32;
  localparam int unsigned SCREEN_COLS  = 64;
  localparam int unsigned SPRITE_WIDTH = 8;

  localparam int unsigned ROW_W = $clog2(SCREEN_ROWS);
  localparam int unsigned COL_W = $clog2(SCREEN_COLS);
  localparam int unsigned PIX_W = 64;

  // Reciprocals for modulo by the screen size (9-bit dividends)
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned ROW_RECIP   = (1 << RECIP_SHIFT) / SCREEN_ROWS;
  localparam int unsigned COL_RECIP   = (1 << RECIP_SHIFT) / SCREEN_COLS;
  localparam int unsigned PROD_W      = 9 + RECIP_SHIFT + 1;

  typedef enum logic {
    MODE_DRAW = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_ROW  = 1'b1
  } state_e;

  // Operands handed to the row engine
  typedef struct packed {
    logic                    valid_row;
    logic [COL_W-1:0]        col0;
    logic [SPRITE_WIDTH-1:0] sprite;
  } eng_req_t;

  // Results of the row engine
  typedef struct packed {
    logic                   hit;
    logic [SCREEN_COLS-1:0] new_row;
    logic [PIX_W-1:0]       pixels;
  } eng_res_t;

  // Row index: v mod SCREEN_ROWS
  function automatic logic [ROW_W-1:0] mod_rows(input logic [8:0] v);
    logic [PROD_W-1:0] prod;
    logic [9:0]        q;
    logic [9:0]        r;
    prod = PROD_W'(v) * PROD_W'(ROW_RECIP);
    q    = 10'(prod >> RECIP_SHIFT);
    r    = 10'(v) - 10'(q * 10'(SCREEN_ROWS));
    if (r >= 10'(SCREEN_ROWS)) begin
      r = r - 10'(SCREEN_ROWS);
    end
    return r[ROW_W-1:0];
  endfunction

  // Column index: v mod SCREEN_COLS
  function automatic logic [COL_W-1:0] mod_cols(input logic [8:0] v);
    logic [PROD_W-1:0] prod;
    logic [9:0]        q;
    logic [9:0]        r;
    prod = PROD_W'(v) * PROD_W'(COL_RECIP);
    q    = 10'(prod >> RECIP_SHIFT);
    r    = 10'(v) - 10'(q * 10'(SCREEN_COLS));
    if (r >= 10'(SCREEN_COLS)) begin
      r = r - 10'(SCREEN_COLS);
    end
    return r[COL_W-1:0];
  endfunction

endpackage

### hw/rtl/sxfb_ram.sv
// ----------------------------------------------------------------------------
// sxfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sxfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/sxfb_row_engine.sv
// ----------------------------------------------------------------------------
// sxfb_row_engine
// Places a sprite byte on a row with wrap, XORs it in, detects collisions
// and formats the row for scan-out.
// ----------------------------------------------------------------------------
module sxfb_row_engine (
  input  logic [sxfb_pkg::SCREEN_COLS-1:0] row_data_i,
  input  sxfb_pkg::eng_req_t               req_i,
  output sxfb_pkg::eng_res_t               res_o
);
  import sxfb_pkg::*;

  logic [SCREEN_COLS-1:0] old_row;
  logic [SCREEN_COLS-1:0] mask;
  logic [COL_W:0]         col;
  logic [PIX_W-1:0]       pix;

  // Rows never written since reset read as all off
  assign old_row = req_i.valid_row ? row_data_i : '0;

  // Build the sprite mask, MSB at the origin column, wrapping the row
  always_comb begin
    mask = '0;
    col  = '0;
    for (int j = 0; j < SPRITE_WIDTH; j++) begin
      col = (COL_W+1)'(req_i.col0) + (COL_W+1)'(j);
      if (col >= (COL_W+1)'(SCREEN_COLS)) begin
        col = col - (COL_W+1)'(SCREEN_COLS);
      end
      if (req_i.sprite[SPRITE_WIDTH-1-j]) begin
        mask[col[COL_W-1:0]] = 1'b1;
      end
    end
  end

  // Map column c to bit 63-c, missing columns read as zero
  always_comb begin
    pix = '0;
    for (int c = 0; c < PIX_W && c < SCREEN_COLS; c++) begin
      pix[PIX_W-1-c] = old_row[c];
    end
  end

  assign res_o.hit     = |(old_row & mask);
  assign res_o.new_row = old_row ^ mask;
  assign res_o.pixels  = pix;

endmodule

### hw/rtl/sprite_xor_framebuffer_core.sv
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_core
// Monochrome framebuffer with XOR sprite-row drawing and row scan-out.
// ----------------------------------------------------------------------------
// Each transfer reads the target row from the frame RAM, then XORs the sprite
// byte in, writes the row back and loads the result register. Items are
// handled one at a time, so in_ready_o drops for the cycle after each accepted
// transfer; a result held by out_ready_i low stretches the modify step until
// the result register frees. A new item may be accepted while the previous
// result still waits. Reset clears the framebuffer at once through per-row
// valid flags, so no clearing pass runs.
module sprite_xor_framebuffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  x_pos_i,
  input  logic [7:0]  y_pos_i,
  input  logic [3:0]  row_offset_i,
  input  logic [7:0]  sprite_byte_i,
  input  logic        first_row_i,
  input  logic        last_row_i,
  input  logic [4:0]  read_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        collision_o,
  output logic        draw_done_o,
  output logic [63:0] row_pixels_o
);
  import sxfb_pkg::*;

  state_e state_q, state_d;

  logic                    in_xfer;
  logic                    out_free;
  logic                    finish;
  logic                    wr_en;
  logic [ROW_W-1:0]        rd_addr;
  logic [SCREEN_COLS-1:0]  rd_data;

  logic                    mode_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col0_q;
  logic [SPRITE_WIDTH-1:0] sprite_q;
  logic                    first_q;
  logic                    last_q;

  logic [SCREEN_ROWS-1:0]  row_valid_q;
  logic                    flag_q, flag_d;

  logic                    out_valid_q;
  logic                    collision_q;
  logic                    draw_done_q;
  logic [PIX_W-1:0]        row_pixels_q;

  eng_req_t                eng_req;
  eng_res_t                eng_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Pick the row to fetch for this item
  always_comb begin
    if (mode_i == MODE_READ) begin
      rd_addr = mod_rows(9'(read_row_i));
    end else begin
      rd_addr = mod_rows(9'(y_pos_i) + 9'(row_offset_i));
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= mode_i;
      row_q    <= rd_addr;
      col0_q   <= mod_cols(9'(x_pos_i));
      sprite_q <= sprite_byte_i;
      first_q  <= first_row_i;
      last_q   <= last_row_i;
    end
  end

  // Sequence: fetch row, then modify and retire once the result slot is free
  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame RAM
  assign wr_en = finish && (mode_q == MODE_DRAW);

  sxfb_ram #(
    .Width (SCREEN_COLS),
    .Depth (SCREEN_ROWS)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (row_q),
    .wr_data_i (eng_res.new_row),
    .rd_en_i   (in_xfer),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // XOR and collision logic
  assign eng_req.valid_row = row_valid_q[row_q];
  assign eng_req.col0      = col0_q;
  assign eng_req.sprite    = sprite_q;

  sxfb_row_engine u_row_engine (
    .row_data_i (rd_data),
    .req_i      (eng_req),
    .res_o      (eng_res)
  );

  // Mark rows as written; reset leaves every row off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (wr_en) begin
      row_valid_q[row_q] <= 1'b1;
    end
  end

  // Collision flag: clear on the first row, set on any lit pixel turned off
  always_comb begin
    flag_d = flag_q;
    if (wr_en) begin
      flag_d = (first_q ? 1'b0 : flag_q) | eng_res.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      collision_q  <= flag_d;
      draw_done_q  <= (mode_q == MODE_DRAW) ? last_q : 1'b0;
      row_pixels_q <= (mode_q == MODE_READ) ? eng_res.pixels : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign collision_o  = collision_q;
  assign draw_done_o  = draw_done_q;
  assign row_pixels_o = row_pixels_q;

endmodule

### hw/rtl/sxfb_checker.sv
// ----------------------------------------------------------------------------
// sxfb_checker
// Port-level checks of the sprite framebuffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sprite_xor_framebuffer_core_assert.svh"

module sxfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        collision_o,
  input logic        draw_done_o,
  input logic [63:0] row_pixels_o
);

  logic        in_xfer;
  logic        out_stall;
  logic [65:0] out_bundle;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign out_bundle = {collision_o, draw_done_o, row_pixels_o};

  // Hold a stalled result
  `SXFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)
  `SXFB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_bundle))
  // One item at a time: no new transfer in the cycle after one
  `SXFB_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_xfer, !in_ready_o)
  // A draw result never carries row pixels
  `SXFB_ASSERT_NOW(a_done_no_pixels, clk_i, rst_ni, out_valid_o && draw_done_o, row_pixels_o == 64'd0)

endmodule

bind sprite_xor_framebuffer_core sxfb_checker u_sxfb_checker (.*);

### tb/tb_sprite_xor_framebuffer_core.sv
// ----------------------------------------------------------------------------
// tb_sprite_xor_framebuffer_core
// Self-checking bench for the XOR sprite framebuffer core.
// ----------------------------------------------------------------------------
// A local copy of the 32x64 pixel store and the collision flag predicts
// each result at the moment its transfer is accepted. A checker compares
// every returned result with the oldest prediction. Stimulus runs from
// hand-picked edge cases through back-to-back rows on one line, whole
// sprites at random places with erase redraws, random noise items and
// full-screen scan-outs, with random gaps on the input side and random
// stalls on the output side.
// ----------------------------------------------------------------------------
module tb_sprite_xor_framebuffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sxfb_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One input item as the block sees it
  typedef struct packed {
    mode_e      mode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_offset;
    logic [7:0] sprite_bits;
    logic       first_row;
    logic       last_row;
    logic [4:0] read_row;
  } fb_item_t;

  // One result of the block
  typedef struct packed {
    logic        collision;
    logic        draw_done;
    logic [63:0] row_pixels;
  } fb_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mode_e       mode = MODE_DRAW;
  logic [7:0]  x_pos = '0;
  logic [7:0]  y_pos = '0;
  logic [3:0]  row_offset = '0;
  logic [7:0]  sprite_byte = '0;
  logic        first_row = 1'b0;
  logic        last_row = 1'b0;
  logic [4:0]  read_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        collision;
  logic        draw_done;
  logic [63:0] row_pixels;

  // Local model of the screen: bit 63 of each word is column 0
  logic [63:0] screen_model [SCREEN_ROWS];
  logic        hit_flag_model;

  fb_result_t  frame_results_q [$];
  fb_result_t  want;

  int unsigned gap_pct     = 30;
  int unsigned stall_pct   = 30;
  int unsigned items_sent  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned n_draws     = 0;
  int unsigned n_reads     = 0;
  int unsigned n_hits      = 0;
  int unsigned n_done      = 0;

  // Current sprite of the random tests, kept for erase redraws
  logic [7:0]  sprite_rows [16];

  sprite_xor_framebuffer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .x_pos_i       (x_pos),
    .y_pos_i       (y_pos),
    .row_offset_i  (row_offset),
    .sprite_byte_i (sprite_byte),
    .first_row_i   (first_row),
    .last_row_i    (last_row),
    .read_row_i    (read_row),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .collision_o   (collision),
    .draw_done_o   (draw_done),
    .row_pixels_o  (row_pixels)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    if ($urandom_range(9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      return idle_len();
    end
    return 0;
  endfunction

  // XOR one sprite row into the screen model, or read one row back
  function automatic fb_result_t apply_item(input fb_item_t it);
    fb_result_t  res;
    logic [4:0]  row;
    logic [5:0]  col;
    logic [8:0]  sum;
    sum = 9'(it.y_pos) + 9'(it.row_offset);
    res = '0;
    if (it.mode == MODE_DRAW) begin
      row = sum[4:0];
      if (it.first_row) begin
        hit_flag_model = 1'b0;
      end
      for (int j = 0; j < SPRITE_WIDTH; j++) begin
        if (it.sprite_bits[SPRITE_WIDTH - 1 - j]) begin
          col = it.x_pos[5:0] + 6'(j);
          if (screen_model[row][63 - col]) begin
            hit_flag_model = 1'b1;
          end
          screen_model[row][63 - col] = ~screen_model[row][63 - col];
        end
      end
      res.draw_done = it.last_row;
    end else begin
      res.row_pixels = screen_model[it.read_row];
    end
    res.collision = hit_flag_model;
    return res;
  endfunction

  // Send one item: optional gap, hold valid until the transfer, then predict
  task automatic send_item(input fb_item_t it);
    int unsigned gap;
    gap = pick_gap(gap_pct);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      mode        <= mode_e'($urandom_range(1));
      x_pos       <= 8'($urandom);
      sprite_byte <= 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid    <= 1'b1;
    mode        <= it.mode;
    x_pos       <= it.x_pos;
    y_pos       <= it.y_pos;
    row_offset  <= it.row_offset;
    sprite_byte <= it.sprite_bits;
    first_row   <= it.first_row;
    last_row    <= it.last_row;
    read_row    <= it.read_row;
    do @(posedge clk_i); while (!in_ready);
    frame_results_q.push_back(apply_item(it));
    items_sent++;
    if (it.mode == MODE_DRAW) begin
      n_draws++;
      if (it.last_row) begin
        n_done++;
      end
    end else begin
      n_reads++;
    end
  endtask

  function automatic fb_item_t draw_item(input logic [7:0] x, input logic [7:0] y,
                                         input logic [3:0] off, input logic [7:0] bits,
                                         input logic first, input logic fin);
    fb_item_t it;
    it = fb_item_t'({$urandom, $urandom});
    it.mode        = MODE_DRAW;
    it.x_pos       = x;
    it.y_pos       = y;
    it.row_offset  = off;
    it.sprite_bits = bits;
    it.first_row   = first;
    it.last_row    = fin;
    return it;
  endfunction

  // Read item with junk in every draw field
  function automatic fb_item_t read_item(input logic [4:0] row);
    fb_item_t it;
    it = fb_item_t'({$urandom, $urandom});
    it.mode     = MODE_READ;
    it.read_row = row;
    return it;
  endfunction

  function automatic logic [7:0] random_pixels();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return 8'hFF;
    end else if (pick < 25) begin
      return 8'h00;
    end
    return 8'($urandom);
  endfunction

  // Draw the stored sprite at (x, y), first and last marks on the ends
  task automatic draw_sprite(input logic [7:0] x, input logic [7:0] y,
                             input int unsigned height);
    for (int r = 0; r < height; r++) begin
      send_item(draw_item(x, y, 4'(r), sprite_rows[r], r == 0, r == height - 1));
    end
  endtask

  // Edge cases: empty read, wraps on both axes, flag clear and carry-over
  task automatic test_directed();
    send_item(read_item(5'd0));
    send_item(draw_item(8'd0, 8'd0, 4'd0, 8'hFF, 1'b1, 1'b0));
    send_item(draw_item(8'd0, 8'd0, 4'd1, 8'h81, 1'b0, 1'b1));
    send_item(read_item(5'd0));
    send_item(read_item(5'd1));
    // column wrap from 60 to 3, row wrap from 255 + 15 to 14
    send_item(draw_item(8'd60, 8'd255, 4'd15, 8'hA5, 1'b1, 1'b1));
    send_item(read_item(5'd14));
    // last column only
    send_item(draw_item(8'd255, 8'd31, 4'd0, 8'h80, 1'b1, 1'b1));
    send_item(read_item(5'd31));
    // lit pixels turned off, then flag held by a row without first mark
    send_item(draw_item(8'd64, 8'd32, 4'd0, 8'hF0, 1'b1, 1'b0));
    send_item(draw_item(8'd128, 8'd64, 4'd0, 8'h0F, 1'b0, 1'b1));
    send_item(read_item(5'd0));
    // first mark clears the flag, empty byte changes nothing
    send_item(draw_item(8'd200, 8'd5, 4'd0, 8'h00, 1'b1, 1'b1));
    send_item(draw_item(8'd10, 8'd5, 4'd0, 8'h3C, 1'b0, 1'b0));
    send_item(draw_item(8'd10, 8'd5, 4'd0, 8'h3C, 1'b1, 1'b0));
    send_item(draw_item(8'd10, 8'd6, 4'd0, 8'h01, 1'b0, 1'b1));
    send_item(read_item(5'd5));
    send_item(read_item(5'd6));
    send_item(draw_item(8'd127, 8'd240, 4'd8, 8'h7E, 1'b1, 1'b1));
    send_item(read_item(5'd24));
  endtask

  // Back-to-back rows on one line with no idling on either side
  task automatic test_back_to_back(input int unsigned rounds);
    logic [7:0] y;
    logic [3:0] off;
    gap_pct   = 0;
    stall_pct = 0;
    for (int n = 0; n < rounds; n++) begin
      y   = 8'($urandom);
      off = 4'($urandom);
      send_item(draw_item(8'($urandom), y, off, random_pixels(), 1'b1, 1'b0));
      send_item(draw_item(8'($urandom), y, off, random_pixels(), 1'b0, 1'b1));
      send_item(read_item(5'(y + 8'(off))));
    end
  endtask

  // Whole sprites at random places, erase redraws, reads and noise
  task automatic test_sprite_draws(input int unsigned target);
    int unsigned stop_at;
    int unsigned height;
    int unsigned pick;
    logic [7:0]  sx;
    logic [7:0]  sy;
    height  = 1;
    sx      = '0;
    sy      = '0;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      // change the idling mix now and then, stretches without any included
      if ($urandom_range(19) == 0) begin
        gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(70);
        stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70);
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        height = ($urandom_range(4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        sx = ($urandom_range(3) == 0) ? 8'($urandom_range(56, 71)) : 8'($urandom);
        sy = ($urandom_range(3) == 0) ? 8'($urandom_range(24, 40)) : 8'($urandom);
        for (int r = 0; r < 16; r++) begin
          sprite_rows[r] = random_pixels();
        end
        draw_sprite(sx, sy, height);
      end else if (pick < 65) begin
        // redraw the last sprite: erases it and raises the flag if it had any lit pixel
        draw_sprite(sx, sy, height);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(read_item(5'(sy + 8'($urandom_range(height - 1)))));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(fb_item_t'({$urandom, $urandom}));
        end
      end
    end
  endtask

  // Scan out every row of the screen
  task automatic test_full_scanout();
    for (int r = 0; r < SCREEN_ROWS; r++) begin
      send_item(read_item(5'(r)));
    end
  endtask

  // Output stalls: random length, rate set by the running test
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result transfer with no item pending");
        error_count++;
      end else begin
        want = frame_results_q.pop_front();
        if (collision !== want.collision) begin
          $error("collision: expected %0d, actual %0d", want.collision, collision);
          error_count++;
        end
        if (draw_done !== want.draw_done) begin
          $error("draw_done: expected %0d, actual %0d", want.draw_done, draw_done);
          error_count++;
        end
        if (row_pixels !== want.row_pixels) begin
          $error("row_pixels: expected %h, actual %h", want.row_pixels, row_pixels);
          error_count++;
        end
        if (want.collision && want.draw_done) begin
          n_hits++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("sprite_xor_framebuffer_core verification failed");
      $finish;
    end
  end

  // Test sequence
  initial begin
    for (int r = 0; r < SCREEN_ROWS; r++) begin
      screen_model[r] = '0;
    end
    for (int r = 0; r < 16; r++) begin
      sprite_rows[r] = '0;
    end
    hit_flag_model = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_back_to_back(50);
    gap_pct   = 30;
    stall_pct = 30;
    test_sprite_draws(850);
    test_full_scanout();
    gap_pct   = 0;
    stall_pct = 0;
    test_full_scanout();

    // Drop valid and drain every pending result
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (frame_results_q.size() != 0) begin
      $error("%0d results never arrived", frame_results_q.size());
      error_count++;
    end

    $display("Covered %0d sprite-row draws (%0d finished draws, %0d with a collision)",
             n_draws, n_done, n_hits);
    $display("and %0d row reads, with %0d mismatches.", n_reads, error_count);
    if (error_count == 0) begin
      $display("sprite_xor_framebuffer_core verification clean");
    end else begin
      $display("sprite_xor_framebuffer_core verification failed");
    end
    $finish;
  end

endmodule
